FILE: rtl/derf_pkg.sv
// Shared types and constants of the dual echo ranger fusion unit.
`timescale 1ns / 1ps
package derf_pkg;

  // Echo width in us to distance in 1/64 cm: (us * DistScale) >> DistShift.
  localparam logic [16:0] DistScale = 17'd71932;
  localparam int unsigned DistShift = 16;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [14:0] MinDistRst     = 15'd128;
  localparam logic [14:0] MaxDistRst     = 15'd25600;
  localparam logic [15:0] StaleLimitRst  = 16'd200;
  localparam logic [15:0] PingSpacingRst = 16'd30;
  localparam logic [14:0] EchoTimeoutRst = 15'd25000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_DIST     = 3'd0,
    REG_MAX_DIST     = 3'd1,
    REG_STALE_LIMIT  = 3'd2,
    REG_PING_SPACING = 3'd3,
    REG_ECHO_TIMEOUT = 3'd4
  } derf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EVAL
  } derf_state_e;

  typedef struct packed {
    logic [14:0] min_distance;
    logic [14:0] max_distance;
    logic [15:0] stale_limit_ms;
    logic [15:0] ping_spacing_ms;
    logic [14:0] echo_timeout_us;
  } derf_cfg_t;

  typedef struct packed {
    logic        action;
    logic [15:0] echo_duration_us;
  } derf_in_t;

  typedef struct packed {
    logic               accepted;
    logic               measured_channel;
    logic               in_range;
    logic [14:0]        channel_average;
    logic [14:0]        fused_distance;
    logic               any_fresh;
    logic [1:0]         fresh_mask;
    logic signed [15:0] spread;
  } derf_out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic        echo;      // measurement taken (not a tick, not dropped)
    logic        in_range;  // echo within timeout and distance within limits, filter update needed
    logic [14:0] distance;
    logic [31:0] now_ms;
  } derf_cmd_t;

endpackage

FILE: rtl/derf_front.sv
// Front end: millisecond clock, ping spacing, timeout and distance conversion.
`timescale 1ns / 1ps
module derf_front
  import derf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  derf_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  derf_in_t  in_data_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output derf_cmd_t cmd_o
);

  logic [31:0] clock_q, clock_d;
  logic [31:0] last_ping_q, last_ping_d;
  logic        ping_seen_q, ping_seen_d;

  logic [32:0] product;
  logic [16:0] dist_full;
  logic [31:0] since_ping;
  logic        too_soon;
  logic        echo_ok;
  logic        take;

  assign take        = in_valid_i && cmd_ready_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  assign product    = {17'd0, in_data_i.echo_duration_us} * {16'd0, DistScale};
  assign dist_full  = product[DistShift +: 17];
  assign since_ping = clock_q - last_ping_q;
  assign too_soon   = ping_seen_q && (since_ping < {16'd0, cfg_i.ping_spacing_ms});
  assign echo_ok    = (in_data_i.echo_duration_us != 16'd0) &&
                      (in_data_i.echo_duration_us <= {1'b0, cfg_i.echo_timeout_us});

  always_comb begin
    clock_d     = clock_q;
    last_ping_d = last_ping_q;
    ping_seen_d = ping_seen_q;
    cmd_o.echo     = 1'b0;
    cmd_o.in_range = 1'b0;
    cmd_o.distance = dist_full[14:0];
    cmd_o.now_ms   = clock_q;
    if (!in_data_i.action) begin
      cmd_o.now_ms = clock_q + 32'd1;
      if (take) begin
        clock_d = clock_q + 32'd1;
      end
    end else if (!too_soon) begin
      cmd_o.echo     = 1'b1;
      cmd_o.in_range = echo_ok && (dist_full >= {2'd0, cfg_i.min_distance}) &&
                       (dist_full <= {2'd0, cfg_i.max_distance});
      if (take) begin
        last_ping_d = clock_q;
        ping_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= '0;
      last_ping_q <= '0;
      ping_seen_q <= 1'b0;
    end else begin
      clock_q     <= clock_d;
      last_ping_q <= last_ping_d;
      ping_seen_q <= ping_seen_d;
    end
  end

endmodule

FILE: rtl/derf_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module derf_queue
  import derf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  derf_cmd_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output derf_cmd_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  derf_cmd_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && cnt_q == CntW'(1)) |=> !pop_valid_o)
    else $error("queue not empty after last item left");
`endif

endmodule

FILE: rtl/derf_back.sv
// Back end: window filter, serial average, freshness, fusion and result register.
`timescale 1ns / 1ps
module derf_back
  import derf_pkg::*;
#(
  parameter int unsigned CHANNELS     = 2,
  parameter int unsigned WINDOW_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  derf_cfg_t cfg_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  derf_cmd_t cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output derf_out_t out_data_o
);

  localparam int unsigned ChW  = $clog2(CHANNELS);
  localparam int unsigned PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(CHANNELS * WINDOW_DEPTH);
  localparam int unsigned SumW = 15 + CntW;
  localparam int unsigned StepW = $clog2(SumW + 1);

  derf_state_e state_q, state_d;
  derf_cmd_t   cmd_q, cmd_d;

  logic [ChW-1:0]   ch_q, ch_d;
  logic [PosW-1:0]  pos_q [CHANNELS];
  logic [PosW-1:0]  pos_d [CHANNELS];
  logic             filled_q [CHANNELS];
  logic             filled_d [CHANNELS];
  logic [14:0]      filt_q [CHANNELS];
  logic [14:0]      filt_d [CHANNELS];
  logic [31:0]      lv_q [CHANNELS];
  logic [31:0]      lv_d [CHANNELS];
  logic [14:0]      held_q, held_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [SumW-1:0]  acc_q, acc_d;
  logic [SumW-1:0]  num_q, num_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;

  logic             out_valid_q, out_valid_d;
  derf_out_t        out_q, out_d;

  logic [14:0]      mem [CHANNELS * WINDOW_DEPTH];
  logic [14:0]      rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_base, mem_wa, mem_ra;

  logic [PosW-1:0]  pos_new;
  logic             filled_new;
  logic [CntW:0]    rem_sh;
  logic             rem_ge;
  logic [CHANNELS-1:0] fresh;
  logic [31:0]      age;
  logic             found;
  logic [14:0]      best;
  logic [14:0]      diff01;
  logic             load_out;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cmd_ready_o = (state_q == ST_IDLE);

  assign mem_base = AddrW'(AddrW'(ch_q) * AddrW'(WINDOW_DEPTH));
  assign mem_wa   = mem_base + AddrW'(pos_q[ch_q]);
  assign mem_ra   = mem_base + AddrW'(k_q);

  assign pos_new    = (pos_q[ch_q] == PosW'(WINDOW_DEPTH - 1)) ? '0 : pos_q[ch_q] + PosW'(1);
  assign filled_new = filled_q[ch_q] || (pos_new == '0);

  assign rem_sh = {rem_q, num_q[SumW-1]};
  assign rem_ge = (rem_sh >= {1'b0, count_q});

  // Freshness and fused minimum over the state as it stands in ST_EVAL.
  always_comb begin
    found = 1'b0;
    best  = '0;
    age   = '0;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      age      = cmd_q.now_ms - lv_q[c];
      fresh[c] = (lv_q[c] != 32'd0) && (age <= {16'd0, cfg_i.stale_limit_ms});
      if (fresh[c] && (!found || filt_q[c] < best)) begin
        best  = filt_q[c];
        found = 1'b1;
      end
    end
  end

  assign diff01 = (filt_q[0] > filt_q[1]) ? filt_q[0] - filt_q[1] : filt_q[1] - filt_q[0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    filled_d    = filled_q;
    filt_d      = filt_q;
    lv_d        = lv_q;
    held_d      = held_q;
    count_d     = count_q;
    k_d         = k_q;
    acc_d       = acc_q;
    num_d       = num_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    load_out    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          if (cmd_i.echo && cmd_i.in_range) begin
            // Write the new sample, then sum the entries written so far.
            mem_we         = 1'b1;
            pos_d[ch_q]    = pos_new;
            filled_d[ch_q] = filled_new;
            count_d        = filled_new ? CntW'(WINDOW_DEPTH) : CntW'(pos_new);
            k_d            = '0;
            acc_d          = '0;
            state_d        = ST_SUM;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_SUM: begin
        mem_re = (k_q < count_q);
        if (k_q != '0) begin
          acc_d = acc_q + SumW'(rdata_q);
        end
        if (k_q == count_q) begin
          num_d   = acc_q + SumW'(rdata_q);
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit a cycle.
        rem_d  = rem_ge ? CntW'(rem_sh - {1'b0, count_q}) : rem_sh[CntW-1:0];
        num_d  = {num_q[SumW-2:0], rem_ge};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(SumW - 1)) begin
          filt_d[ch_q] = num_d[14:0];
          lv_d[ch_q]   = (cmd_q.now_ms != 32'd0) ? cmd_q.now_ms : 32'd1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          load_out                = 1'b1;
          out_valid_d             = 1'b1;
          out_d.accepted          = cmd_q.echo;
          out_d.measured_channel  = cmd_q.echo ? ch_q[0] : 1'b0;
          out_d.in_range          = cmd_q.echo && cmd_q.in_range;
          out_d.channel_average   = cmd_q.echo ? filt_q[ch_q] : '0;
          out_d.fused_distance    = (cmd_q.echo && found) ? best : held_q;
          out_d.any_fresh         = |fresh;
          out_d.fresh_mask        = fresh[1:0];
          out_d.spread            = (fresh[0] && fresh[1]) ? signed'({1'b0, diff01})
                                                           : -16'sd1;
          if (cmd_q.echo) begin
            if (found) begin
              held_d = best;
            end
            ch_d = (ch_q == ChW'(CHANNELS - 1)) ? '0 : ch_q + ChW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= cmd_i.distance;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    count_q <= count_d;
    acc_q   <= acc_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      held_q      <= '0;
      k_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        pos_q[c]    <= '0;
        filled_q[c] <= 1'b0;
        filt_q[c]   <= '0;
        lv_q[c]     <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      held_q      <= held_d;
      k_q         <= k_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      filled_q    <= filled_d;
      filt_q      <= filt_d;
      lv_q        <= lv_d;
    end
  end

`ifndef SYNTH
  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_SUM) |-> (count_q != '0 &&
      count_q <= CntW'(WINDOW_DEPTH)))
    else $error("window count out of range during average");

  a_chan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= ChW'(CHANNELS - 1))
    else $error("active channel beyond channel count");

  a_load_from_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EVAL))
    else $error("result loaded outside evaluation step");

  a_eval_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && load_out) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after result");
`endif

endmodule

FILE: rtl/dual_echo_ranger_fusion_unit.sv
// Top level of the dual echo ranger fusion unit: config registers, front, queue, back.
// Timing: the queue registers each item; the back takes one only in ST_IDLE, and a tick or
//   an echo without a filter update goes straight to ST_EVAL; an in-range echo runs ST_SUM
//   and ST_DIV first. ST_EVAL registers the result once the output register is free; the back
//   sequencer (window sum, serial divide) sets the pace, the queue absorbs bursts.
// Reset: config registers take their reset values, control and filter state clear; the
//   window memory is not cleared, entries are read only after written.
`timescale 1ns / 1ps
module dual_echo_ranger_fusion_unit
  import derf_pkg::*;
#(
  parameter int unsigned CHANNELS     = 2,
  parameter int unsigned WINDOW_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  derf_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output derf_out_t           out_data_o
);

  derf_cfg_t cfg_q;

  logic      f2q_valid, f2q_ready;
  derf_cmd_t f2q_cmd;
  logic      q2b_valid, q2b_ready;
  derf_cmd_t q2b_cmd;

  // Configuration registers; writes to unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance    <= MinDistRst;
      cfg_q.max_distance    <= MaxDistRst;
      cfg_q.stale_limit_ms  <= StaleLimitRst;
      cfg_q.ping_spacing_ms <= PingSpacingRst;
      cfg_q.echo_timeout_us <= EchoTimeoutRst;
    end else if (cfg_we_i) begin
      case (derf_reg_e'(cfg_idx_i))
        REG_MIN_DIST:     cfg_q.min_distance    <= cfg_wdata_i[14:0];
        REG_MAX_DIST:     cfg_q.max_distance    <= cfg_wdata_i[14:0];
        REG_STALE_LIMIT:  cfg_q.stale_limit_ms  <= cfg_wdata_i;
        REG_PING_SPACING: cfg_q.ping_spacing_ms <= cfg_wdata_i;
        REG_ECHO_TIMEOUT: cfg_q.echo_timeout_us <= cfg_wdata_i[14:0];
        default: begin
        end
      endcase
    end
  end

  // Front: advance the ms clock, drop echoes that come too soon, convert and classify.
  derf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f2q_valid),
    .cmd_ready_i (f2q_ready),
    .cmd_o       (f2q_cmd)
  );

  // Hold classified items while the back is busy averaging or waiting to hand on a result.
  derf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f2q_valid),
    .push_ready_o (f2q_ready),
    .push_data_i  (f2q_cmd),
    .pop_valid_o  (q2b_valid),
    .pop_ready_i  (q2b_ready),
    .pop_data_o   (q2b_cmd)
  );

  // Back: update the window, average, evaluate freshness and fusion, register the item.
  derf_back #(
    .CHANNELS     (CHANNELS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q2b_valid),
    .cmd_ready_o (q2b_ready),
    .cmd_i       (q2b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the dual echo ranger fusion unit: directed and random items.
`timescale 1ns / 1ps
module tb_top;
  import derf_pkg::*;

  // Item kinds carried in the action field.
  localparam logic ActTick = 1'b0;
  localparam logic ActEcho = 1'b1;

  localparam int unsigned Chans       = 2;
  localparam int unsigned WinDepth    = 4;
  // Leave margin after the longest in-range echo before touching registers.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 100;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  derf_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  derf_out_t           out_data_o;

  dual_echo_ranger_fusion_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Ranging state mirror: register copy, ms clock, ping spacing, windows, fusion.
  // ---------------------------------------------------------------------------
  derf_cfg_t   cfg_m = '{min_distance: MinDistRst, max_distance: MaxDistRst,
                         stale_limit_ms: StaleLimitRst, ping_spacing_ms: PingSpacingRst,
                         echo_timeout_us: EchoTimeoutRst};
  logic [31:0] clock_ms_m  = '0;
  logic [31:0] last_ping_m = '0;
  logic        ping_seen_m = 1'b0;
  int unsigned active_ch_m = 0;
  logic [14:0] window_m     [Chans][WinDepth];
  int unsigned win_pos_m    [Chans] = '{default: 0};
  bit          win_full_m   [Chans] = '{default: 1'b0};
  logic [14:0] avg_m        [Chans] = '{default: '0};
  logic [31:0] last_valid_m [Chans] = '{default: '0};   // zero means never valid
  logic [14:0] held_m = '0;

  derf_in_t    pending_pings[$];     // items waiting for the driver
  derf_out_t   expected_fusion[$];   // predicted results in acceptance order

  int unsigned n_queued = 0, n_items = 0, n_accepted = 0, n_in_range = 0, n_dropped = 0;
  int unsigned n_checked = 0, n_settings = 0, mismatches = 0;
  int unsigned stall_odds = 0;       // 0 = no idling, else a burst starts with odds of 1 in N
  int unsigned send_gap = 0, recv_gap = 0;
  bit          item_taken = 1'b0;

  // Clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic chan_fresh(int unsigned k);
    return (last_valid_m[k] != '0) && ((clock_ms_m - last_valid_m[k]) <= cfg_m.stale_limit_ms);
  endfunction

  // Advance the mirror by one item and return the result it must produce.
  function automatic derf_out_t predict_fusion(derf_in_t it);
    derf_out_t   r;
    logic [32:0] prod;
    logic [16:0] distance;
    logic [1:0]  mask;
    logic [14:0] best;
    bit          found;
    int unsigned ch, cnt, sum, a, b, k;
    r     = '0;
    mask  = '0;
    best  = '0;
    found = 1'b0;
    ch    = 0;
    n_items++;
    if (it.action == ActTick) begin
      clock_ms_m = clock_ms_m + 32'd1;
    end else if (ping_seen_m && (clock_ms_m - last_ping_m) < cfg_m.ping_spacing_ms) begin
      n_dropped++;
    end else begin
      ch          = active_ch_m;
      last_ping_m = clock_ms_m;
      ping_seen_m = 1'b1;
      n_accepted++;
      r.accepted         = 1'b1;
      r.measured_channel = ch[0];
      // Zero or over the timeout: no filter update, channel still advances.
      if (it.echo_duration_us != '0 && it.echo_duration_us <= cfg_m.echo_timeout_us) begin
        prod     = 33'(it.echo_duration_us) * 33'(DistScale);
        distance = prod[DistShift +: 17];
        if (distance >= 17'(cfg_m.min_distance) && distance <= 17'(cfg_m.max_distance)) begin
          window_m[ch][win_pos_m[ch]] = distance[14:0];
          win_pos_m[ch] = (win_pos_m[ch] + 1) % WinDepth;
          if (win_pos_m[ch] == 0) win_full_m[ch] = 1'b1;
          // While the window fills, average only over the entries written so far.
          cnt = win_full_m[ch] ? WinDepth : win_pos_m[ch];
          sum = 0;
          for (k = 0; k < cnt; k++) sum += window_m[ch][k];
          avg_m[ch] = 15'(sum / cnt);
          // A valid reading at clock zero is stamped 1, since 0 means never.
          last_valid_m[ch] = (clock_ms_m != '0) ? clock_ms_m : 32'd1;
          r.in_range = 1'b1;
          n_in_range++;
        end
      end
      r.channel_average = avg_m[ch];
      active_ch_m = (ch + 1) % Chans;
      // Fuse only after an accepted echo; hold when nothing is fresh.
      for (k = 0; k < Chans; k++) begin
        if (chan_fresh(k) && (!found || avg_m[k] < best)) begin
          best  = avg_m[k];
          found = 1'b1;
        end
      end
      if (found) held_m = best;
    end
    for (k = 0; k < Chans; k++) mask[k] = chan_fresh(k);
    r.fused_distance = held_m;
    r.any_fresh      = |mask;
    r.fresh_mask     = mask;
    if (mask == 2'b11) begin
      a = avg_m[0];
      b = avg_m[1];
      r.spread = 16'((a > b) ? a - b : b - a);
    end else begin
      r.spread = '1;   // either channel stale
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("MISMATCH result %0d: %s", n_checked, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%h, want 0x%h", name, got, want));
  endtask

  // Monitor: check delivered results first, then predict the item taken at this edge,
  // so a fresh expectation can never be matched against an older result.
  always @(posedge clk_i) begin : monitor
    derf_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (expected_fusion.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_fusion.pop_front();
          check_field("accepted",         out_data_o.accepted,         want.accepted);
          check_field("measured_channel", out_data_o.measured_channel, want.measured_channel);
          check_field("in_range",         out_data_o.in_range,         want.in_range);
          check_field("channel_average",  out_data_o.channel_average,  want.channel_average);
          check_field("fused_distance",   out_data_o.fused_distance,   want.fused_distance);
          check_field("any_fresh",        out_data_o.any_fresh,        want.any_fresh);
          check_field("fresh_mask",       out_data_o.fresh_mask,       want.fresh_mask);
          check_field("spread",           out_data_o.spread,           want.spread);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_fusion.push_back(predict_fusion(in_data_i));
        item_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued items, hold until taken; random stall bursts both sides.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    logic     nxt_valid;
    derf_in_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (item_taken) begin
      nxt_valid  = 1'b0;
      item_taken = 1'b0;
    end
    if (!nxt_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_pings.size() != 0) begin
        if (stall_odds != 0 && $urandom_range(stall_odds, 1) == 1) begin
          send_gap = $urandom_range(17);
        end else begin
          nxt_data  = pending_pings.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
    // Receiver back-pressure.
    if (recv_gap != 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(stall_odds, 1) == 1) begin
      recv_gap = $urandom_range(17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(logic act, logic [15:0] dur);
    derf_in_t it;
    it.action           = act;
    it.echo_duration_us = dur;
    pending_pings.push_back(it);
    n_queued++;
  endtask

  // Ticks carry random durations: the field must be ignored on a tick.
  task automatic push_ticks(int unsigned n);
    repeat (n) push_item(ActTick, 16'($urandom));
  endtask

  // Wait until every item went through and every result came back, then let the block settle.
  task automatic wait_drained();
    while (pending_pings.size() != 0 || in_valid_i || expected_fusion.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (derf_reg_e'(idx))
      REG_MIN_DIST:     cfg_m.min_distance    = val[14:0];
      REG_MAX_DIST:     cfg_m.max_distance    = val[14:0];
      REG_STALE_LIMIT:  cfg_m.stale_limit_ms  = val;
      REG_PING_SPACING: cfg_m.ping_spacing_ms = val;
      REG_ECHO_TIMEOUT: cfg_m.echo_timeout_us = val[14:0];
      default: ;   // unmapped index: drop the write
    endcase
  endtask

  task automatic apply_config(logic [14:0] mn, logic [14:0] mx, logic [15:0] stale,
                              logic [15:0] spacing, logic [14:0] tmo);
    write_reg(REG_MIN_DIST, 16'(mn));
    write_reg(REG_MAX_DIST, 16'(mx));
    write_reg(REG_STALE_LIMIT, stale);
    write_reg(REG_PING_SPACING, spacing);
    write_reg(REG_ECHO_TIMEOUT, 16'(tmo));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // One random phase: mostly tick runs near the ping spacing followed by an echo,
  // with durations aimed at the accepted distance band, plus some plain noise.
  task automatic run_phase(logic [14:0] mn, logic [14:0] mx, logic [15:0] stale,
                           logic [15:0] spacing, logic [14:0] tmo,
                           int unsigned n, int unsigned odds);
    int unsigned dlo, dhi, gap_hi, gap_lo, long_hi, sel, target;
    logic [15:0] dur;
    wait_drained();
    apply_config(mn, mx, stale, spacing, tmo);
    stall_odds = odds;
    dlo = (32'(mn) << DistShift) / 32'(DistScale);
    dhi = ((32'(mx) + 1) << DistShift) / 32'(DistScale);
    if (dhi > tmo) dhi = tmo;
    gap_hi  = (spacing + 3 > 60) ? 60 : spacing + 3;
    gap_lo  = (gap_hi > 5) ? gap_hi - 5 : 0;
    long_hi = (stale + spacing + 8 > 300) ? 300 : stale + spacing + 8;
    target  = n_queued + n;
    while (n_queued < target) begin
      if ($urandom_range(99) < 10) begin
        push_item(1'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(5) == 0) push_ticks($urandom_range(long_hi));
        else push_ticks($urandom_range(gap_hi, gap_lo));
        sel = $urandom_range(99);
        if (sel < 60) begin
          dur = (dlo <= dhi) ? 16'($urandom_range(dhi, dlo)) : 16'($urandom_range(tmo, 1));
        end else if (sel < 68) begin
          dur = '0;
        end else if (sel < 80) begin
          dur = 16'($urandom_range(65535, tmo + 1));
        end else if (sel < 88) begin
          case ($urandom_range(3))
            0: dur = 16'(tmo);
            1: dur = 16'(dlo);
            2: dur = 16'(dhi);
            default: dur = 16'(dhi + 1);
          endcase
        end else begin
          dur = 16'($urandom);
        end
        push_item(ActEcho, dur);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idx;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: in-range echo at clock zero, then one too soon after it.
    stall_odds = 5;
    push_item(ActEcho, 16'd1000);
    push_item(ActEcho, 16'd1000);
    push_ticks(1);
    wait_drained();

    // Unmapped indexes must leave the settings alone.
    for (idx = int'(REG_ECHO_TIMEOUT) + 1; idx < (1 << CfgIdxW); idx++)
      write_reg(CfgIdxW'(idx), 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    // Timeouts, distance limits on both sides, alternation and going stale.
    apply_config(15'd128, 15'd25600, 16'd3, 16'd1, 15'd25000);
    push_item(ActEcho, 16'd0);
    push_ticks(1);
    push_item(ActEcho, 16'hFFFF);
    push_ticks(1);
    push_item(ActEcho, 16'd25000);
    push_ticks(1);
    push_item(ActEcho, 16'd1);
    push_ticks(1);
    push_item(ActEcho, 16'd117);
    push_ticks(1);
    push_item(ActEcho, 16'd23323);
    push_ticks(1);
    push_item(ActEcho, 16'd4000);
    push_ticks(5);
    push_item(ActEcho, 16'd4000);
    wait_drained();

    // Widest limits, no spacing: back-to-back echoes fill and wrap the windows.
    apply_config(15'd0, 15'd32767, 16'hFFFF, 16'd0, 15'd29000);
    push_item(ActEcho, 16'd29000);
    push_item(ActEcho, 16'd29001);
    push_item(ActEcho, 16'd1);
    push_item(ActEcho, 16'hFFFF);
    repeat (5) push_item(ActEcho, 16'd9000);

    // Random phases.
    run_phase(MinDistRst, MaxDistRst, StaleLimitRst, PingSpacingRst, EchoTimeoutRst, 250, 6);
    run_phase(15'd0, 15'd32767, 16'hFFFF, 16'd0, 15'd29000, 200, 0);
    run_phase(15'd32767, 15'd0, 16'd0, 16'hFFFF, 15'd1, 60, 4);
    repeat (5) begin
      run_phase(15'($urandom_range(3000)), 15'($urandom_range(32767, 15000)),
                16'($urandom_range(60)), 16'($urandom_range(5)),
                15'($urandom_range(29000, 10000)), 200,
                ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 3));
    end
    // Closing stretch at full rate.
    run_phase(15'd128, 15'd25600, 16'd40, 16'd2, 15'd25000, 150, 0);
    wait_drained();

    $display("Ran %0d items under %0d register settings; checked %0d results, %0d mismatches.",
             n_items, n_settings, n_checked, mismatches);
    $display("Echoes taken: %0d (%0d in range), dropped by ping spacing: %0d.",
             n_accepted, n_in_range, n_dropped);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #2_000_000;
    $display("Run did not finish in time: %0d results still outstanding.",
             expected_fusion.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: dual_echo_ranger_fusion_unit.f
rtl/derf_pkg.sv
rtl/derf_front.sv
rtl/derf_queue.sv
rtl/derf_back.sv
rtl/dual_echo_ranger_fusion_unit.sv
tb/tb_top.sv
